>>> sv/base64_stream_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// base64_stream_decoder_core_defines
// Assertion macros shared by the decoder's checker.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define B64D_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define B64D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always on (for reset behavior)
`define B64D_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/b64d_pkg.sv
// ---------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier of the base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef logic [5:0] sextet_type;

   typedef struct packed {
      logic       legal;
      logic       is_pad;
      sextet_type value;
   } char_class_type;

   // one queued job: up to three result items, packed in emit order
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;    // number of result items, 1..3
      logic            error;
      logic            msg_end;
   } b64d_job_type;

   function automatic char_class_type b64d_classify(input logic [7:0] c);
      char_class_type r;
      r.legal  = 1'b1;
      r.is_pad = 1'b0;
      r.value  = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.value = 6'd63;
      end else if (c == PAD_CHAR) begin
         r.is_pad = 1'b1;
      end else begin
         r.legal = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> sv/base64_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 (RFC 4648 alphabet) text-to-byte decoder.
// ---------------------------------------------------------------------------
// Takes one text character per cycle and emits decoded bytes, one result
// item per cycle while rsp_ready is high. A character item is accepted in
// the cycle it arrives as long as the job queue has room; the group's
// fourth character produces up to three result items, which the back end
// drains one per cycle from the queue while rsp_ready is high, so four
// characters in yield at most three results and the input sustains one
// item per cycle. Input stalls only when rsp_ready has been low long enough
// to fill the QUEUE_DEPTH-entry job queue. Result items are registered.
// Illegal characters (anything outside A-Z a-z 0-9 + / =, including all
// bytes of 128 or more) give one error item and then the rest of the
// message is skipped silently up to the item flagged req_last; a message
// that ends inside a group of four also gives one error item. Error items
// carry a zero byte. '=' decodes as zero anywhere; in the third or fourth
// place of a group it suppresses the second or third byte.
// ---------------------------------------------------------------------------
module base64_stream_decoder_core
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_error,
   output logic       rsp_last,
   output logic       rsp_msg_end
);

   // front -> queue
   logic         push_valid, push_ready;
   b64d_job_type push_job;
   // queue -> back
   logic         pop_valid, pop_ready;
   b64d_job_type pop_job;

   // classifier and group tracker: one job per item that causes results
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_char   (req_char),
      .req_last   (req_last),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // decouples character intake from result drain
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // job serializer with registered result outputs
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_byte    (rsp_byte),
      .rsp_error   (rsp_error),
      .rsp_last    (rsp_last),
      .rsp_msg_end (rsp_msg_end)
   );

endmodule

>>> sv/b64d_front.sv
// ---------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the group of four and builds output jobs.
// ---------------------------------------------------------------------------
module b64d_front
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_char,
   input  logic         req_last,
   output logic         push_valid,
   output b64d_job_type push_job,
   input  logic         push_ready
);

   logic [1:0]     slot_ff, slot_in;
   logic [17:0]    held_ff, held_in;
   logic           pad3_ff, pad3_in;
   logic           drop_ff, drop_in;
   logic           accept;
   char_class_type cls;
   sextet_type     s0, s1, s2;
   logic [7:0]     b0, b1, b2;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign cls       = b64d_classify(req_char);
   assign s0        = held_ff[17:12];
   assign s1        = held_ff[11:6];
   assign s2        = held_ff[5:0];
   assign b0        = {s0, s1[5:4]};
   assign b1        = {s1[3:0], s2[5:2]};
   assign b2        = {s2[1:0], cls.value};

   always_comb begin
      slot_in    = slot_ff;
      held_in    = held_ff;
      pad3_in    = pad3_ff;
      drop_in    = drop_ff;
      push_valid = 1'b0;
      push_job   = '{data: '0, count: 2'd1, error: 1'b1, msg_end: req_last};
      if (accept) begin
         priority if (drop_ff) begin
            if (req_last) begin
               drop_in = 1'b0;
               slot_in = '0;
               held_in = '0;
               pad3_in = 1'b0;
            end
         end else if (!cls.legal) begin
            push_valid = 1'b1;
            drop_in    = !req_last;
            slot_in    = '0;
            held_in    = '0;
            pad3_in    = 1'b0;
         end else if (slot_ff != 2'd3) begin
            held_in = {held_ff[11:0], cls.value};
            slot_in = slot_ff + 2'd1;
            if (slot_ff == 2'd2) pad3_in = cls.is_pad;
            if (req_last) begin
               // message ends inside a group
               push_valid = 1'b1;
               slot_in    = '0;
               held_in    = '0;
               pad3_in    = 1'b0;
            end
         end else begin
            push_valid       = 1'b1;
            push_job.error   = 1'b0;
            push_job.data[0] = b0;
            push_job.data[1] = pad3_ff ? b2 : b1;
            push_job.data[2] = b2;
            push_job.count   = 2'd1 + {1'b0, !pad3_ff} + {1'b0, !cls.is_pad};
            slot_in          = '0;
            held_in          = '0;
            pad3_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         held_ff <= '0;
         pad3_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         held_ff <= held_in;
         pad3_ff <= pad3_in;
         drop_ff <= drop_in;
      end
   end

endmodule

>>> sv/b64d_queue.sv
// ---------------------------------------------------------------------------
// b64d_queue
// Short job FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  b64d_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output b64d_job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64d_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> sv/b64d_back.sv
// ---------------------------------------------------------------------------
// b64d_back
// Unpacks jobs into registered result items, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module b64d_back
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  b64d_job_type pop_job,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_byte,
   output logic         rsp_error,
   output logic         rsp_last,
   output logic         rsp_msg_end
);

   logic         cur_valid_ff, cur_valid_in;
   b64d_job_type cur_job_ff, cur_job_in;
   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;
   logic         rsp_error_ff, rsp_error_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_msg_end_ff, rsp_msg_end_in;
   logic         out_load, is_final;
   logic [7:0]   sel_byte;

   assign out_load  = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign is_final  = (idx_ff == cur_job_ff.count - 2'd1);
   assign pop_ready = !cur_valid_ff || (out_load && is_final);

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel_byte = cur_job_ff.data[0];
         2'd1:    sel_byte = cur_job_ff.data[1];
         default: sel_byte = cur_job_ff.data[2];
      endcase
   end

   always_comb begin
      cur_valid_in   = cur_valid_ff;
      cur_job_in     = cur_job_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_error_in   = rsp_error_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_msg_end_in = rsp_msg_end_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_byte_in    = sel_byte;
         rsp_error_in   = cur_job_ff.error;
         rsp_last_in    = is_final;
         rsp_msg_end_in = is_final && cur_job_ff.msg_end;
         idx_in         = idx_ff + 2'd1;
         if (is_final) cur_valid_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         cur_valid_in = 1'b1;
         cur_job_in   = pop_job;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff     <= cur_job_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_error_ff   <= rsp_error_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_msg_end_ff <= rsp_msg_end_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_byte    = rsp_byte_ff;
   assign rsp_error   = rsp_error_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_msg_end = rsp_msg_end_ff;

endmodule

>>> sv/b64d_checker.sv
// ---------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64_stream_decoder_core_defines.svh"

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_error,
   input logic       rsp_last,
   input logic       rsp_msg_end
);

   `B64D_ASSERT_NOW(a_err_zero, clock, reset,
                    rsp_valid && rsp_error, rsp_byte == 8'd0,
                    "error item with nonzero byte")

   `B64D_ASSERT_NOW(a_end_last, clock, reset,
                    rsp_valid && (rsp_msg_end || rsp_error), rsp_last,
                    "message end or error item not marked last")

   `B64D_ASSERT_NEXT(a_hold, clock, reset,
                     rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_byte) && $stable(rsp_error)
                        && $stable(rsp_last) && $stable(rsp_msg_end),
                     "stalled result item changed")

   `B64D_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid,
                            "result valid right after reset")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_byte    (rsp_byte),
   .rsp_error   (rsp_error),
   .rsp_last    (rsp_last),
   .rsp_msg_end (rsp_msg_end)
);
